[rtl/dctr_pkg.sv]
package dctr_pkg;

  localparam int ID_W = 6;

  typedef enum logic [2:0] {
    CMD_NEW    = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUBMIT = 3'd2,
    CMD_DONE   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_READY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_FULL      = 3'd1,
    FAULT_BAD_ID    = 3'd2,
    FAULT_SUCC_FULL = 3'd3,
    FAULT_PHASE     = 3'd4
  } fault_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_CHK,
    ST_ADD_INC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE_CHK,
    ST_WALK_RD,
    ST_WALK_S,
    ST_WALK_D,
    ST_REL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [ID_W-1:0]   id;
    fault_t            fault;
    logic              all_done;
    logic              last;
  } res_t;

endpackage

[rtl/dctr_ram.sv]
module dctr_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dctr_obuf.sv]
module dctr_obuf (
  input  logic             clk,
  input  logic             rst,
  input  dctr_pkg::res_t   push,
  output logic             room,
  input  logic             stall,
  output dctr_pkg::res_t   held
);

  logic                valid;
  dctr_pkg::res_t      data;

  assign room = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room && push.valid) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (room && push.valid) begin
      data <= push;
    end
  end

  always_comb begin
    held       = data;
    held.valid = valid;
  end

endmodule

[rtl/dctr_ctrl.sv]
module dctr_ctrl #(
  parameter int MAX_NODES      = 64,
  parameter int MAX_SUCCESSORS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [2:0]                 cmd,
  input  logic [dctr_pkg::ID_W-1:0]  pred_id,
  input  logic [dctr_pkg::ID_W-1:0]  node_id,
  output dctr_pkg::res_t             push,
  input  logic                       room
);

  localparam int OW  = dctr_pkg::ID_W;
  localparam int IW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int LW  = $clog2(MAX_SUCCESSORS + 1);
  localparam int SD  = MAX_NODES * MAX_SUCCESSORS;
  localparam int SAW = $clog2(SD);
  localparam int PW  = $clog2(SD);
  localparam int NW  = 1 + LW + PW;
  localparam logic [SAW-1:0] MS_A  = SAW'(MAX_SUCCESSORS);
  localparam logic [LW-1:0]  MS_L  = LW'(MAX_SUCCESSORS);
  localparam logic [CW-1:0]  MN_C  = CW'(MAX_NODES);

  dctr_pkg::state_t  state, state_next;
  dctr_pkg::cmd_e_t  cmd_q, cmd_q_next;
  dctr_pkg::kind_t   res_kind, res_kind_next;
  dctr_pkg::fault_t  res_fault, res_fault_next;
  logic [IW-1:0]     res_id, res_id_next;
  logic [CW-1:0]     node_total, node_total_next;
  logic [CW-1:0]     tasks_left, tasks_left_next;
  logic              submitted, submitted_next;
  logic [CW-1:0]     idx, idx_next;
  logic [IW-1:0]     cur_id, cur_id_next;
  logic [IW-1:0]     new_id, new_id_next;
  logic [IW-1:0]     rel_id, rel_id_next;
  logic [LW-1:0]     j, j_next;
  logic [LW-1:0]     len_q, len_q_next;
  logic              held_v, held_v_next;
  logic [IW-1:0]     held_id, held_id_next;

  logic              node_we;
  logic [IW-1:0]     node_waddr, node_raddr;
  logic [NW-1:0]     node_wdata, node_rdata;
  logic              st_we;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [IW-1:0]     st_wdata, st_rdata;

  logic              rd_fin;
  logic [LW-1:0]     rd_len;
  logic [PW-1:0]     rd_pend;
  logic [PW-1:0]     pend_adj;
  logic              pred_bad, nid_bad;

  assign rd_pend = node_rdata[PW-1:0];
  assign rd_len  = node_rdata[PW+LW-1:PW];
  assign rd_fin  = node_rdata[NW-1];

  assign pend_adj = rd_pend + ((state == dctr_pkg::ST_ADD_INC) ? PW'(1) : {PW{1'b1}});

  assign pred_bad = (32'(pred_id) + 32'd1) >= 32'(node_total);
  assign nid_bad  = 32'(node_id) >= 32'(node_total);

  assign cmd_stall = (state != dctr_pkg::ST_IDLE);

  dctr_ram #(.W(NW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk  (clk),
    .we   (node_we),
    .waddr(node_waddr),
    .wdata(node_wdata),
    .raddr(node_raddr),
    .rdata(node_rdata)
  );

  dctr_ram #(.W(IW), .DEPTH(SD)) u_succ_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dctr_pkg::ST_IDLE;
      node_total <= '0;
      tasks_left <= '0;
      submitted  <= 1'b0;
      held_v     <= 1'b0;
    end else begin
      state      <= state_next;
      node_total <= node_total_next;
      tasks_left <= tasks_left_next;
      submitted  <= submitted_next;
      held_v     <= held_v_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q     <= cmd_q_next;
    res_kind  <= res_kind_next;
    res_fault <= res_fault_next;
    res_id    <= res_id_next;
    idx       <= idx_next;
    cur_id    <= cur_id_next;
    new_id    <= new_id_next;
    rel_id    <= rel_id_next;
    j         <= j_next;
    len_q     <= len_q_next;
    held_id   <= held_id_next;
  end

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    res_kind_next   = res_kind;
    res_fault_next  = res_fault;
    res_id_next     = res_id;
    node_total_next = node_total;
    tasks_left_next = tasks_left;
    submitted_next  = submitted;
    idx_next        = idx;
    cur_id_next     = cur_id;
    new_id_next     = new_id;
    rel_id_next     = rel_id;
    j_next          = j;
    len_q_next      = len_q;
    held_v_next     = held_v;
    held_id_next    = held_id;

    node_we    = 1'b0;
    node_waddr = cur_id;
    node_wdata = '0;
    node_raddr = cur_id;
    st_we      = 1'b0;
    st_waddr   = SAW'(cur_id) * MS_A + SAW'(rd_len);
    st_wdata   = new_id;
    st_raddr   = SAW'(cur_id) * MS_A + SAW'(j);

    push          = '0;
    push.all_done = (tasks_left == '0);

    case (state)
      dctr_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_q_next     = dctr_pkg::cmd_e_t'(cmd);
          res_kind_next  = dctr_pkg::KIND_ACK;
          res_fault_next = dctr_pkg::FAULT_NONE;
          res_id_next    = '0;
          case (cmd)
            dctr_pkg::CMD_NEW: begin
              state_next = dctr_pkg::ST_FIN;
              if (submitted) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_PHASE;
              end else if (node_total == MN_C) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_FULL;
              end else begin
                node_we         = 1'b1;
                node_waddr      = IW'(node_total);
                res_id_next     = IW'(node_total);
                node_total_next = node_total + CW'(1);
              end
            end
            dctr_pkg::CMD_ADD: begin
              if (submitted || node_total == '0) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_PHASE;
                state_next     = dctr_pkg::ST_FIN;
              end else if (pred_bad) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_BAD_ID;
                state_next     = dctr_pkg::ST_FIN;
              end else begin
                cur_id_next = IW'(pred_id);
                new_id_next = IW'(node_total - CW'(1));
                node_raddr  = IW'(pred_id);
                state_next  = dctr_pkg::ST_ADD_CHK;
              end
            end
            dctr_pkg::CMD_SUBMIT: begin
              if (submitted) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_PHASE;
                state_next     = dctr_pkg::ST_FIN;
              end else begin
                submitted_next  = 1'b1;
                tasks_left_next = node_total;
                idx_next        = '0;
                state_next      = dctr_pkg::ST_SCAN_RD;
              end
            end
            dctr_pkg::CMD_DONE: begin
              if (!submitted) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_PHASE;
                state_next     = dctr_pkg::ST_FIN;
              end else if (nid_bad) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_BAD_ID;
                state_next     = dctr_pkg::ST_FIN;
              end else begin
                cur_id_next = IW'(node_id);
                node_raddr  = IW'(node_id);
                state_next  = dctr_pkg::ST_DONE_CHK;
              end
            end
            dctr_pkg::CMD_CLEAR: begin
              state_next = dctr_pkg::ST_FIN;
              if (submitted && tasks_left != '0) begin
                res_kind_next  = dctr_pkg::KIND_ERROR;
                res_fault_next = dctr_pkg::FAULT_PHASE;
              end else begin
                node_total_next = '0;
                tasks_left_next = '0;
                submitted_next  = 1'b0;
              end
            end
            default: begin
              state_next = dctr_pkg::ST_IDLE;
            end
          endcase
        end
      end

      dctr_pkg::ST_ADD_CHK: begin
        if (rd_len >= MS_L) begin
          res_kind_next  = dctr_pkg::KIND_ERROR;
          res_fault_next = dctr_pkg::FAULT_SUCC_FULL;
          state_next     = dctr_pkg::ST_FIN;
        end else begin
          node_we    = 1'b1;
          node_wdata = {rd_fin, rd_len + LW'(1), rd_pend};
          st_we      = 1'b1;
          node_raddr = new_id;
          state_next = dctr_pkg::ST_ADD_INC;
        end
      end

      dctr_pkg::ST_ADD_INC: begin
        node_we    = 1'b1;
        node_waddr = new_id;
        node_wdata = {rd_fin, rd_len, pend_adj};
        state_next = dctr_pkg::ST_FIN;
      end

      dctr_pkg::ST_SCAN_RD: begin
        if (idx == node_total) begin
          state_next = dctr_pkg::ST_FIN;
        end else begin
          node_raddr = IW'(idx);
          state_next = dctr_pkg::ST_SCAN_CHK;
        end
      end

      dctr_pkg::ST_SCAN_CHK: begin
        if (rd_pend == '0) begin
          rel_id_next = IW'(idx);
          state_next  = dctr_pkg::ST_REL;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = dctr_pkg::ST_SCAN_RD;
        end
      end

      dctr_pkg::ST_DONE_CHK: begin
        if (rd_pend != '0 || rd_fin || tasks_left == '0) begin
          res_kind_next  = dctr_pkg::KIND_ERROR;
          res_fault_next = dctr_pkg::FAULT_PHASE;
          state_next     = dctr_pkg::ST_FIN;
        end else begin
          node_we         = 1'b1;
          node_wdata      = {1'b1, rd_len, rd_pend};
          len_q_next      = rd_len;
          tasks_left_next = tasks_left - CW'(1);
          j_next          = '0;
          state_next      = dctr_pkg::ST_WALK_RD;
        end
      end

      dctr_pkg::ST_WALK_RD: begin
        if (j == len_q) begin
          state_next = dctr_pkg::ST_FIN;
        end else begin
          state_next = dctr_pkg::ST_WALK_S;
        end
      end

      dctr_pkg::ST_WALK_S: begin
        node_raddr  = st_rdata;
        rel_id_next = st_rdata;
        state_next  = dctr_pkg::ST_WALK_D;
      end

      dctr_pkg::ST_WALK_D: begin
        if (rd_pend == '0) begin
          j_next     = j + LW'(1);
          state_next = dctr_pkg::ST_WALK_RD;
        end else begin
          node_we    = 1'b1;
          node_waddr = rel_id;
          node_wdata = {rd_fin, rd_len, pend_adj};
          if (pend_adj == '0) begin
            state_next = dctr_pkg::ST_REL;
          end else begin
            j_next     = j + LW'(1);
            state_next = dctr_pkg::ST_WALK_RD;
          end
        end
      end

      dctr_pkg::ST_REL: begin
        if (!held_v || room) begin
          if (held_v) begin
            push.valid = 1'b1;
            push.kind  = dctr_pkg::KIND_READY;
            push.id    = OW'(held_id);
            push.fault = dctr_pkg::FAULT_NONE;
          end
          held_v_next  = 1'b1;
          held_id_next = rel_id;
          if (cmd_q == dctr_pkg::CMD_SUBMIT) begin
            idx_next   = idx + CW'(1);
            state_next = dctr_pkg::ST_SCAN_RD;
          end else begin
            j_next     = j + LW'(1);
            state_next = dctr_pkg::ST_WALK_RD;
          end
        end
      end

      dctr_pkg::ST_FIN: begin
        if (room) begin
          push.valid = 1'b1;
          push.last  = 1'b1;
          if (held_v) begin
            push.kind  = dctr_pkg::KIND_READY;
            push.id    = OW'(held_id);
            push.fault = dctr_pkg::FAULT_NONE;
          end else begin
            push.kind  = res_kind;
            push.id    = OW'(res_id);
            push.fault = res_fault;
          end
          held_v_next = 1'b0;
          state_next  = dctr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dctr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/dependency_count_task_release_core.sv]
// Channel   Handshake              Payload
// command   cmd_valid / cmd_stall  cmd, pred_id, node_id
// result    res_valid / res_stall  kind, task_id, fault, all_done, last
//
// One command at a time; cmd_stall is high until its last result is in the output register.
// New node and clear answer at once; add predecessor reads and checks, then updates the node table.
// Submit scans all nodes and complete walks the successor list, releasing tasks that reach zero.
// Reset (rst, synchronous) empties the graph at once; table entries are rewritten on allocation.
// A stalled result holds in the output register; the sequencer waits when it is full and stalled.
module dependency_count_task_release_core #(
  parameter int MAX_NODES      = 64,
  parameter int MAX_SUCCESSORS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] cmd,
  input  logic [5:0] pred_id,
  input  logic [5:0] node_id,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] kind,
  output logic [5:0] task_id,
  output logic [2:0] fault,
  output logic       all_done,
  output logic       last
);

  dctr_pkg::res_t push;
  dctr_pkg::res_t held;
  logic           room;

  dctr_ctrl #(
    .MAX_NODES     (MAX_NODES),
    .MAX_SUCCESSORS(MAX_SUCCESSORS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .pred_id  (pred_id),
    .node_id  (node_id),
    .push     (push),
    .room     (room)
  );

  dctr_obuf u_obuf (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .stall(res_stall),
    .held (held)
  );

  assign res_valid = held.valid;
  assign kind      = held.kind;
  assign task_id   = held.id;
  assign fault     = held.fault;
  assign all_done  = held.all_done;
  assign last      = held.last;

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd <= dctr_pkg::CMD_CLEAR) |=> cmd_stall)
    else $error("valid command did not start the sequencer");

  a_unused_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd > dctr_pkg::CMD_CLEAR) |=> !cmd_stall)
    else $error("unused command occupied the sequencer");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == dctr_pkg::KIND_ERROR) |-> (last && fault != dctr_pkg::FAULT_NONE))
    else $error("error result not final or without fault");

  a_ready_no_fault: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind != dctr_pkg::KIND_ERROR) |-> fault == dctr_pkg::FAULT_NONE)
    else $error("fault code on a non-error result");

endmodule

[tb/sv/dependency_count_task_release_core_test.sv]
`timescale 1ns / 100ps

module dependency_count_task_release_core_test;

  localparam int NODES      = 64;
  localparam int SUCCS      = 8;
  localparam int RAND_ITEMS = 125;
  localparam int HOLD_CYC   = 400;
  localparam int SETTLE_CYC = 250;
  localparam int LIMIT_CYC  = 400000;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam bit CHK   = 1'b1;
  localparam bit NOCHK = 1'b0;

  typedef struct packed {
    dctr_pkg::kind_t  kind;
    logic [5:0]       id;
    dctr_pkg::fault_t fault;
    logic             all_done;
    logic             last;
  } release_t;

  typedef struct packed {
    bit               typed;
    dctr_pkg::kind_t  kind;
    logic [5:0]       id;
    dctr_pkg::fault_t fault;
  } row_note_t;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] pid;
    logic [5:0] nid;
    row_note_t  chk;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [2:0] cmd;
  logic [5:0] pred_id;
  logic [5:0] node_id;
  logic       res_valid;
  logic       res_stall;
  logic [1:0] kind;
  logic [5:0] task_id;
  logic [2:0] fault;
  logic       all_done;
  logic       last;

  // graph mirror
  logic [8:0] pend_cnt [NODES];
  logic [5:0] succ_tab [NODES][SUCCS];
  logic [3:0] succ_len [NODES];
  bit         done_flag [NODES];
  logic [6:0] node_cnt;
  logic [6:0] tasks_open;
  bit         graph_live;

  release_t   step_q[$];
  release_t   expected_release_q[$];
  row_note_t  offer_q[$];
  dir_row_t   dir_tab[$];

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned cmd_cnt;
  int unsigned shape_cnt;
  int unsigned graph_size;
  int unsigned edge_pct;
  bit          big_mode;
  bit          fan_mode;
  bit          full_seen;
  bit          hold_req;
  bit          hold_done;
  int          phase;

  dependency_count_task_release_core #(
    .MAX_NODES      (NODES),
    .MAX_SUCCESSORS (SUCCS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pred_id   (pred_id),
    .node_id   (node_id),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .kind      (kind),
    .task_id   (task_id),
    .fault     (fault),
    .all_done  (all_done),
    .last      (last)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void clear_graph();
    for (int i = 0; i < NODES; i++) begin
      pend_cnt[i]  = '0;
      succ_len[i]  = '0;
      done_flag[i] = 1'b0;
      for (int j = 0; j < SUCCS; j++) succ_tab[i][j] = '0;
    end
    node_cnt   = '0;
    tasks_open = '0;
    graph_live = 1'b0;
  endfunction

  function automatic void note(dctr_pkg::kind_t k, logic [5:0] id, dctr_pkg::fault_t f);
    release_t r;
    r.kind     = k;
    r.id       = id;
    r.fault    = f;
    r.all_done = 1'b0;
    r.last     = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  task automatic predict_release(input logic [2:0] op, input logic [5:0] pid,
                                 input logic [5:0] nid);
    logic [5:0] newest;
    logic [3:0] len;
    logic [5:0] s;
    step_q.delete();
    case (op)
      dctr_pkg::CMD_NEW: begin
        if (graph_live) note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_PHASE);
        else if (node_cnt >= 7'(NODES)) note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_FULL);
        else begin
          pend_cnt[node_cnt[5:0]]  = '0;
          succ_len[node_cnt[5:0]]  = '0;
          done_flag[node_cnt[5:0]] = 1'b0;
          note(dctr_pkg::KIND_ACK, node_cnt[5:0], dctr_pkg::FAULT_NONE);
          node_cnt++;
        end
      end
      dctr_pkg::CMD_ADD: begin
        if (graph_live || node_cnt == '0) note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_PHASE);
        else begin
          newest = 6'(node_cnt - 7'd1);
          if (pid >= newest) note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_BAD_ID);
          else if (succ_len[pid] >= 4'(SUCCS))
            note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_SUCC_FULL);
          else begin
            succ_tab[pid][succ_len[pid][2:0]] = newest;
            succ_len[pid]++;
            pend_cnt[newest]++;
            note(dctr_pkg::KIND_ACK, '0, dctr_pkg::FAULT_NONE);
          end
        end
      end
      dctr_pkg::CMD_SUBMIT: begin
        if (graph_live) note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_PHASE);
        else begin
          graph_live = 1'b1;
          tasks_open = node_cnt;
          for (int i = 0; i < int'(node_cnt); i++)
            if (pend_cnt[i] == '0) note(dctr_pkg::KIND_READY, 6'(i), dctr_pkg::FAULT_NONE);
          if (step_q.size() == 0) note(dctr_pkg::KIND_ACK, '0, dctr_pkg::FAULT_NONE);
        end
      end
      dctr_pkg::CMD_DONE: begin
        if (!graph_live) note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_PHASE);
        else if ({1'b0, nid} >= node_cnt) note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_BAD_ID);
        else if (pend_cnt[nid] != '0 || done_flag[nid] || tasks_open == '0)
          note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_PHASE);
        else begin
          done_flag[nid] = 1'b1;
          len = (succ_len[nid] > 4'(SUCCS)) ? 4'(SUCCS) : succ_len[nid];
          for (int i = 0; i < int'(len); i++) begin
            s = succ_tab[nid][i];
            if ({1'b0, s} < node_cnt && pend_cnt[s] != '0) begin
              pend_cnt[s]--;
              if (pend_cnt[s] == '0) note(dctr_pkg::KIND_READY, s, dctr_pkg::FAULT_NONE);
            end
          end
          tasks_open--;
          if (step_q.size() == 0) note(dctr_pkg::KIND_ACK, '0, dctr_pkg::FAULT_NONE);
        end
      end
      dctr_pkg::CMD_CLEAR: begin
        if (graph_live && tasks_open != '0)
          note(dctr_pkg::KIND_ERROR, '0, dctr_pkg::FAULT_PHASE);
        else begin
          clear_graph();
          note(dctr_pkg::KIND_ACK, '0, dctr_pkg::FAULT_NONE);
        end
      end
      default: ;
    endcase
    foreach (step_q[k]) begin
      step_q[k].all_done = (tasks_open == '0);
      step_q[k].last     = (k == step_q.size() - 1);
      expected_release_q.insert(expected_release_q.size(), step_q[k]);
    end
  endtask

  always @(posedge clk) begin
    release_t  want;
    row_note_t rn;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_release_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d task_id %0d fault %0d all_done %0b last %0b",
                   $time, kind, task_id, fault, all_done, last);
          fail_cnt++;
        end else begin
          want = expected_release_q.pop_front();
          if (kind !== want.kind || task_id !== want.id || fault !== want.fault ||
              all_done !== want.all_done || last !== want.last) begin
            $display("%0t: expected kind %0d task_id %0d fault %0d all_done %0b last %0b, %s",
                     $time, want.kind, want.id, want.fault, want.all_done, want.last,
                     "got:");
            $display("%0t:   actual kind %0d task_id %0d fault %0d all_done %0b last %0b",
                     $time, kind, task_id, fault, all_done, last);
            fail_cnt++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        rn = offer_q.pop_front();
        predict_release(cmd, pred_id, node_id);
        if (rn.typed && (step_q.size() != 1 || step_q[0].kind != rn.kind ||
                         step_q[0].id != rn.id || step_q[0].fault != rn.fault)) begin
          $display("%0t: cmd %0d expected kind %0d task_id %0d fault %0d, predicted %0d entries",
                   $time, cmd, rn.kind, rn.id, rn.fault, step_q.size());
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int k = 0; k < HOLD_CYC; k++) begin
          res_stall <= 1'b1;
          @(negedge clk);
        end
      end
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic send_cmd(input logic [2:0] op, input logic [5:0] pid,
                          input logic [5:0] nid, input row_note_t rn);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    offer_q.insert(offer_q.size(), rn);
    cmd_valid <= 1'b1;
    cmd       <= op;
    pred_id   <= pid;
    node_id   <= nid;
    if (op <= dctr_pkg::CMD_CLEAR) cmd_cnt++;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    cmd_valid <= 1'b0;
    while (expected_release_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic row(input logic [2:0] op, input logic [5:0] pid, input logic [5:0] nid,
                     input bit typed, input dctr_pkg::kind_t k, input logic [5:0] id,
                     input dctr_pkg::fault_t f);
    dir_row_t r;
    r.op        = op;
    r.pid       = pid;
    r.nid       = nid;
    r.chk.typed = typed;
    r.chk.kind  = k;
    r.chk.id    = id;
    r.chk.fault = f;
    dir_tab.insert(dir_tab.size(), r);
  endtask

  function automatic void next_shape();
    shape_cnt++;
    big_mode  = (shape_cnt == 1);
    fan_mode  = (shape_cnt == 2);
    full_seen = 1'b0;
    if (big_mode) begin
      graph_size = NODES;
      edge_pct   = 4;
    end else if (fan_mode) begin
      graph_size = 11;
      edge_pct   = 60;
    end else begin
      graph_size = $urandom_range(1, 10);
      edge_pct   = $urandom_range(20, 70);
    end
  endfunction

  task automatic random_item();
    logic [2:0]  op;
    logic [5:0]  pid;
    logic [5:0]  nid;
    int unsigned ready_ids[$];
    row_note_t   rn;
    rn  = '0;
    pid = 6'($urandom);
    nid = 6'($urandom);
    if (!big_mode && $urandom_range(0, 99) < 10) begin
      op = 3'($urandom_range(0, 7));
    end else if (!graph_live) begin
      if (big_mode && node_cnt >= 7'(graph_size)) begin
        if (!full_seen) begin
          op        = dctr_pkg::CMD_NEW;
          full_seen = 1'b1;
        end else begin
          op = dctr_pkg::CMD_CLEAR;
          next_shape();
        end
      end else if (node_cnt >= 7'd2 && $urandom_range(0, 99) < edge_pct) begin
        op  = dctr_pkg::CMD_ADD;
        pid = fan_mode ? 6'd0 : 6'($urandom_range(0, int'(node_cnt) - 2));
      end else if (node_cnt < 7'(graph_size)) begin
        op = dctr_pkg::CMD_NEW;
      end else begin
        op = dctr_pkg::CMD_SUBMIT;
      end
    end else if (tasks_open != '0) begin
      for (int i = 0; i < int'(node_cnt); i++)
        if (pend_cnt[i] == '0 && !done_flag[i]) ready_ids.insert(ready_ids.size(), i);
      op = dctr_pkg::CMD_DONE;
      if (ready_ids.size() != 0)
        nid = 6'(ready_ids[$urandom_range(0, ready_ids.size() - 1)]);
    end else begin
      op = dctr_pkg::CMD_CLEAR;
      next_shape();
    end
    send_cmd(op, pid, nid, rn);
  endtask

  initial begin
    rst             = 1'b1;
    cmd_valid       = 1'b0;
    cmd             = '0;
    pred_id         = '0;
    node_id         = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    fail_cnt        = 0;
    cycle_cnt       = 0;
    cmd_cnt         = 0;
    shape_cnt       = 0;
    graph_size      = 0;
    edge_pct        = 0;
    big_mode        = 1'b0;
    fan_mode        = 1'b0;
    full_seen       = 1'b0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    phase           = 0;
    clear_graph();

    row(dctr_pkg::CMD_ADD,    6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(CMD_RSVD7,            6'd63, 6'd63, NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(CMD_RSVD6,            6'd21, 6'd42, NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_NEW,    6'd63, 6'd63, CHK,   dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_NEW,    6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ACK,   6'd1,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_ADD,    6'd1,  6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_BAD_ID);
    row(dctr_pkg::CMD_ADD,    6'd63, 6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_BAD_ID);
    row(dctr_pkg::CMD_ADD,    6'd0,  6'd63, CHK,   dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_NEW,    6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ACK,   6'd2,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_ADD,    6'd0,  6'd0,  NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_ADD,    6'd1,  6'd0,  NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_SUBMIT, 6'd0,  6'd0,  NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_NEW,    6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(dctr_pkg::CMD_SUBMIT, 6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(dctr_pkg::CMD_CLEAR,  6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd63, CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_BAD_ID);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd2,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd0,  NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd1,  NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd2,  NOCHK, dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_DONE,   6'd0,  6'd2,  CHK,   dctr_pkg::KIND_ERROR, 6'd0,
        dctr_pkg::FAULT_PHASE);
    row(dctr_pkg::CMD_CLEAR,  6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);
    row(dctr_pkg::CMD_SUBMIT, 6'd0,  6'd0,  CHK,   dctr_pkg::KIND_ACK,   6'd0,
        dctr_pkg::FAULT_NONE);

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_cmd(dir_tab[i].op, dir_tab[i].pid, dir_tab[i].nid, dir_tab[i].chk);
    wait_drain();

    cmd_cnt = 0;
    while (cmd_cnt < RAND_ITEMS) begin
      if (int'((cmd_cnt / 20) % 4) != phase) begin
        wait_drain();
        phase = int'((cmd_cnt / 20) % 4);
        case (phase)
          1:       begin sender_idle_pct = 57; recv_stall_pct = 0;  end
          2:       begin sender_idle_pct = 0;  recv_stall_pct = 57; end
          3:       begin sender_idle_pct = 29; recv_stall_pct = 29; end
          default: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
      end
      // long receiver hold while commands keep coming
      if (cmd_cnt >= 90 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      random_item();
    end
    wait_drain();

    if (fail_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
